// File: hw/rtl/rads_pkg.sv
`default_nettype none

package rads_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SF   = 3'd0,
      CSR_BW   = 3'd1,
      CSR_CR   = 3'd2,
      CSR_CRC  = 3'd3,
      CSR_DUTY = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] payload_bytes;
      logic       send_ok;
   } req_type;

   typedef struct packed {
      logic [28:0] airtime_us;
      logic [25:0] next_interval_ms;
   } rsp_type;

   localparam logic [3:0]  SF_RESET = 4'd9;
   localparam logic [18:0] BW_RESET = 19'd125000;
   localparam logic [3:0]  CR_RESET = 4'd5;

   localparam logic [3:0]  SF_MIN   = 4'd6;
   localparam logic [3:0]  SF_MAX   = 4'd12;
   localparam logic [18:0] BW_MIN   = 19'd7800;
   localparam logic [18:0] BW_MAX   = 19'd500000;
   localparam logic [3:0]  CR_MIN   = 4'd5;
   localparam logic [3:0]  CR_MAX   = 4'd8;
   localparam logic [18:0] LOWDR_BW = 19'd125000;
   localparam logic [3:0]  LOWDR_SF = 4'd11;

   localparam logic [19:0] AIR_SCALE = 20'd1000000;
   localparam logic [16:0] IVL_SCALE = 17'd99000;

   localparam logic [25:0] IVL_FLOOR = 26'd1000;
   localparam logic [25:0] IVL_FREE  = 26'd10000;
   localparam logic [25:0] IVL_FAIL  = 26'd2000;

   // restoring divider geometry
   localparam int DIV_Q_W = 29;
   localparam int DIV_N_W = 44;
   localparam int DIV_D_W = 21;
   localparam int DIV_H_W = DIV_N_W - DIV_Q_W;

   // ceil(2^16 / k); exact floor for numerators below 1024
   function automatic logic [15:0] rads_recip(input logic [3:0] k);
      logic [15:0] r;
      case (k)
         4'd6:    r = 16'd10923;
         4'd7:    r = 16'd9363;
         4'd8:    r = 16'd8192;
         4'd9:    r = 16'd7282;
         4'd10:   r = 16'd6554;
         4'd11:   r = 16'd5958;
         4'd12:   r = 16'd5462;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/radio_airtime_duty_scheduler.sv
// Packet airtime and duty-cycle interval computer. Each accepted packet (start high, busy low)
// yields one result strobe on rsp_valid; a new packet may be accepted on every cycle, and busy
// is high only during reset. A result passes through five front stages, then the 29-stage
// restoring divider (one quotient bit per stage), then the output register. Results are
// a single-cycle strobe the receiver cannot stall. Configuration writes are taken whenever the
// block is out of reset and must be issued only while no packet is in flight.
`default_nettype none

module radio_airtime_duty_scheduler import rads_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef struct packed {
      logic valid;
      logic ok;
   } ctl_type;

   logic [3:0]  sf_ff;
   logic [18:0] bw_ff;
   logic [3:0]  cr_ff;
   logic        crc_ff;
   logic        duty_ff;

   logic [3:0]         sf_c;
   logic [18:0]        bw_c;
   logic [3:0]         cr_c;
   logic               lowdr;
   logic [3:0]         k;
   logic [DIV_D_W-1:0] dvs;

   logic accept;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff   <= SF_RESET;
         bw_ff   <= BW_RESET;
         cr_ff   <= CR_RESET;
         crc_ff  <= 1'b1;
         duty_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SF:   sf_ff   <= csr_data[3:0];
            CSR_BW:   bw_ff   <= csr_data[18:0];
            CSR_CR:   cr_ff   <= csr_data[3:0];
            CSR_CRC:  crc_ff  <= csr_data[0];
            CSR_DUTY: duty_ff <= csr_data[0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      sf_c  = (sf_ff < SF_MIN) ? SF_MIN : ((sf_ff > SF_MAX) ? SF_MAX : sf_ff);
      bw_c  = (bw_ff < BW_MIN) ? BW_MIN : ((bw_ff > BW_MAX) ? BW_MAX : bw_ff);
      cr_c  = (cr_ff < CR_MIN) ? CR_MIN : ((cr_ff > CR_MAX) ? CR_MAX : cr_ff);
      lowdr = (bw_c == LOWDR_BW) && (sf_c >= LOWDR_SF);
      k     = lowdr ? (sf_c - 4'd2) : sf_c;
      dvs   = {bw_c, 2'b00};
   end

   // stage 1: capture
   logic       s1_valid_ff;
   logic       s1_ok_ff;
   logic [7:0] s1_len_ff;

   // stage 2: symbol bits rounded up to whole nibbles, biased for ceil by k
   logic [11:0] pos;
   logic [11:0] neg;
   logic [11:0] nbits;
   logic [11:0] nround;
   logic [9:0]  s2_mk_in;
   logic        s2_valid_ff;
   logic        s2_ok_ff;
   logic [9:0]  s2_mk_ff;

   // stage 3: reciprocal multiply
   logic [25:0] prod;
   logic        s3_valid_ff;
   logic        s3_ok_ff;
   logic [6:0]  s3_q_ff;

   // stage 4: symbol count and chip scaling
   logic [9:0]  nsym;
   logic [11:0] pcount;
   logic        s4_valid_ff;
   logic        s4_ok_ff;
   logic [23:0] s4_x_ff;

   // stage 5: dividends
   logic               s5_valid_ff;
   logic               s5_ok_ff;
   logic [DIV_N_W-1:0] s5_air_ff;
   logic [DIV_N_W-1:0] s5_ivl_ff;

   always_comb begin
      pos      = 12'({s1_len_ff, 3'b000}) + 12'd28 + (crc_ff ? 12'd16 : 12'd0);
      neg      = 12'({sf_c, 2'b00});
      nbits    = (pos > neg) ? (pos - neg) : 12'd0;
      nround   = nbits + 12'd3;
      s2_mk_in = nround[11:2] + 10'(k) - 10'd1;
      prod     = 26'(s2_mk_ff) * 26'(rads_recip(k));
      nsym     = 10'd8 + 10'(s3_q_ff) * 10'(cr_c);
      pcount   = 12'd49 + 12'({nsym, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ok_ff  <= req_payload.send_ok;
      s1_len_ff <= req_payload.payload_bytes;
      s2_ok_ff  <= s1_ok_ff;
      s2_mk_ff  <= s2_mk_in;
      s3_ok_ff  <= s2_ok_ff;
      s3_q_ff   <= prod[22:16];
      s4_ok_ff  <= s3_ok_ff;
      s4_x_ff   <= 24'(pcount) << sf_c;
      s5_ok_ff  <= s4_ok_ff;
      s5_air_ff <= 44'(s4_x_ff) * 44'(AIR_SCALE);
      s5_ivl_ff <= 44'(s4_x_ff) * 44'(IVL_SCALE);
   end

   logic [DIV_Q_W-1:0] air_q;
   logic [DIV_Q_W-1:0] ivl_q;

   rads_div u_air_div (
      .clock    (clock),
      .dividend (s5_air_ff),
      .divisor  (dvs),
      .quotient (air_q)
   );

   rads_div u_ivl_div (
      .clock    (clock),
      .dividend (s5_ivl_ff),
      .divisor  (dvs),
      .quotient (ivl_q)
   );

   ctl_type ctl_ff [DIV_Q_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_Q_W; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= '{valid: s5_valid_ff, ok: s5_ok_ff};
         for (int i = 1; i < DIV_Q_W; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   rsp_type rsp_payload_in;
   rsp_type rsp_payload_ff;
   logic    rsp_valid_ff;

   always_comb begin
      if (!ctl_ff[DIV_Q_W-1].ok) begin
         rsp_payload_in.airtime_us       = '0;
         rsp_payload_in.next_interval_ms = IVL_FAIL;
      end else begin
         rsp_payload_in.airtime_us = air_q;
         if (!duty_ff) begin
            rsp_payload_in.next_interval_ms = IVL_FREE;
         end else if (ivl_q < DIV_Q_W'(IVL_FLOOR)) begin
            rsp_payload_in.next_interval_ms = IVL_FLOOR;
         end else begin
            rsp_payload_in.next_interval_ms = ivl_q[25:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_ff[DIV_Q_W-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   ast_ivl_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.next_interval_ms >= IVL_FLOOR)
      else $error("interval below floor");

   ast_fail_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.airtime_us == '0 |-> rsp_payload.next_interval_ms == IVL_FAIL)
      else $error("zero airtime without failure interval");

   ast_duty_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && duty_ff && rsp_payload.airtime_us != '0
         && rsp_payload.next_interval_ms != IVL_FLOOR
      |-> 29'(rsp_payload.next_interval_ms) <= rsp_payload.airtime_us)
      else $error("duty interval exceeds airtime");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rads_div.sv
`default_nettype none

module rads_div import rads_pkg::*; (
   input  logic               clock,
   input  logic [DIV_N_W-1:0] dividend,
   input  logic [DIV_D_W-1:0] divisor,
   output logic [DIV_Q_W-1:0] quotient
);

   typedef struct packed {
      logic [DIV_D_W-1:0] rem;
      logic [DIV_Q_W-1:0] pend;
      logic [DIV_Q_W-1:0] quo;
      logic [DIV_D_W-1:0] dvs;
   } div_stage_type;

   // one quotient bit per stage; remainder stays below the divisor
   function automatic div_stage_type div_step(input div_stage_type s);
      logic [DIV_D_W:0] t;
      logic [DIV_D_W:0] diff;
      div_stage_type    r;
      t      = {s.rem, s.pend[DIV_Q_W-1]};
      diff   = t - {1'b0, s.dvs};
      r      = s;
      r.pend = {s.pend[DIV_Q_W-2:0], 1'b0};
      if (t >= {1'b0, s.dvs}) begin
         r.rem = diff[DIV_D_W-1:0];
         r.quo = {s.quo[DIV_Q_W-2:0], 1'b1};
      end else begin
         r.rem = t[DIV_D_W-1:0];
         r.quo = {s.quo[DIV_Q_W-2:0], 1'b0};
      end
      return r;
   endfunction

   div_stage_type head;
   div_stage_type stage_in [DIV_Q_W];
   div_stage_type stage_ff [DIV_Q_W];

   always_comb begin
      head.rem  = {{(DIV_D_W-DIV_H_W){1'b0}}, dividend[DIV_N_W-1:DIV_Q_W]};
      head.pend = dividend[DIV_Q_W-1:0];
      head.quo  = '0;
      head.dvs  = divisor;
   end

   always_comb begin
      stage_in[0] = div_step(head);
      for (int i = 1; i < DIV_Q_W; i++) begin
         stage_in[i] = div_step(stage_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DIV_Q_W; i++) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   assign quotient = stage_ff[DIV_Q_W-1].quo;

endmodule

`default_nettype wire
